// ----- rtl/core/ptl_pkg.sv -----
// ----------------------------------------------------------------------------
// ptl_pkg: shared definitions for the point to line distance block
// Widths, register indexes and the control group that travels with an item.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int OUT_WIDTH       = 32;
  localparam int QUOT_WIDTH      = 2 * OUT_WIDTH;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_AXES        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic sat;
  } ptl_ctl_t;

endpackage

// ----- rtl/core/ptl_ifs.sv -----
// ----------------------------------------------------------------------------
// ptl_ifs: item channels of the point to line distance block
// Valid/ready channels for query points and for distance results.
// ----------------------------------------------------------------------------
interface ptl_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ptl_out_if;
  import ptl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_WIDTH-1:0] distance;
  logic                 degenerate;

  modport source (output valid, distance, degenerate, input ready);
  modport sink   (input valid, distance, degenerate, output ready);
endinterface

// ----- rtl/core/point_to_line_distance_3d.sv -----
// ----------------------------------------------------------------------------
// point_to_line_distance_3d: distance from 3D points to a configured line
// Each input item carries a point; each result item carries its distance to
// the line through origin_x/y/z with direction dir_x/y/z, in unsigned Q16.16.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block does not enforce it. The pipeline
// runs through the cross product and squared lengths, the divider (an input
// register, then one quotient bit per stage), the square root (one root bit
// per stage) and the output register. Throughput is one item per cycle while
// the receiver does not stall; every stage is a register stage. A zero
// direction gives distance 0 with degenerate set; a distance of 2^16 or more
// saturates at all ones. Reset empties the pipeline and sets the line to the
// unit x axis. When the receiver stalls a held result, the whole pipeline
// holds and in_ch.ready falls; no item is lost or repeated.
// ----------------------------------------------------------------------------
module point_to_line_distance_3d #(
  parameter int COORD_WIDTH = ptl_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ptl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ptl_in_if.sink                        in_ch,
  ptl_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ptl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);
  import ptl_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic signed [CW-1:0]   org_r [NUM_AXES];
  logic signed [CW-1:0]   dir_r [NUM_AXES];
  logic                   adv;
  logic                   cc_valid;
  logic [4*CW+5:0]        cc;
  logic [2*CW-1:0]        dd;
  ptl_ctl_t               q_ctl;
  logic [QUOT_WIDTH-1:0]  quot;
  ptl_ctl_t               r_ctl;
  logic [OUT_WIDTH-1:0]   root;
  logic                   out_valid_r;
  logic [OUT_WIDTH-1:0]   distance_r;
  logic                   degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= CW'(1) << FRAC_BITS;
      dir_r[1] <= '0;
      dir_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: org_r[0] <= cfg_data;
        REG_ORIGIN_Y: org_r[1] <= cfg_data;
        REG_ORIGIN_Z: org_r[2] <= cfg_data;
        REG_DIR_X:    dir_r[0] <= cfg_data;
        REG_DIR_Y:    dir_r[1] <= cfg_data;
        REG_DIR_Z:    dir_r[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;

  ptl_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .pt_x     (in_ch.point_x),
    .pt_y     (in_ch.point_y),
    .pt_z     (in_ch.point_z),
    .org_x    (org_r[0]),
    .org_y    (org_r[1]),
    .org_z    (org_r[2]),
    .dir_x    (dir_r[0]),
    .dir_y    (dir_r[1]),
    .dir_z    (dir_r[2]),
    .cc_valid (cc_valid),
    .cc       (cc),
    .dd       (dd)
  );

  ptl_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cc_valid (cc_valid),
    .cc       (cc),
    .dd       (dd),
    .q_ctl    (q_ctl),
    .quot     (quot)
  );

  ptl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .q_ctl (q_ctl),
    .quot  (quot),
    .r_ctl (r_ctl),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= r_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degen_r <= r_ctl.degen;
      if (r_ctl.degen) begin
        distance_r <= '0;
      end else if (r_ctl.sat) begin
        distance_r <= '1;
      end else begin
        distance_r <= root;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.distance   = distance_r;
  assign out_ch.degenerate = degen_r;

`ifndef NO_ASSERTIONS
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && degen_r |-> distance_r == '0)
    else $error("degenerate result with non-zero distance");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while a result is stalled");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(distance_r))
    else $error("stalled result changed");
`endif

endmodule

// ----- rtl/core/ptl_front.sv -----
// ----------------------------------------------------------------------------
// ptl_front: cross product and squared lengths
// Forms |(p - o) x d|^2 for each item over six stages, and |d|^2 from the
// configured direction.
// ----------------------------------------------------------------------------
module ptl_front #(
  parameter int CW = ptl_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [CW-1:0]     pt_x,
  input  logic signed [CW-1:0]     pt_y,
  input  logic signed [CW-1:0]     pt_z,
  input  logic signed [CW-1:0]     org_x,
  input  logic signed [CW-1:0]     org_y,
  input  logic signed [CW-1:0]     org_z,
  input  logic signed [CW-1:0]     dir_x,
  input  logic signed [CW-1:0]     dir_y,
  input  logic signed [CW-1:0]     dir_z,
  output logic                     cc_valid,
  output logic [4*CW+5:0]          cc,
  output logic [2*CW-1:0]          dd
);
  import ptl_pkg::*;

  localparam int AW  = CW + 1;
  localparam int PW  = 2 * CW + 1;
  localparam int CWD = 2 * CW + 2;
  localparam int H   = CW + 1;
  localparam int SQW = 4 * H;
  localparam int CCW = 4 * CW + 6;
  localparam int DDW = 2 * CW;

  logic signed [CW-1:0]  pt  [NUM_AXES];
  logic signed [CW-1:0]  org [NUM_AXES];
  logic signed [CW-1:0]  dir [NUM_AXES];
  logic [5:0]            v_r;
  logic signed [AW-1:0]  a_r    [NUM_AXES];
  logic signed [PW-1:0]  prod_r [6];
  logic [CWD-1:0]        cabs_r [NUM_AXES];
  logic signed [CWD-1:0] c_nxt  [NUM_AXES];
  logic [2*H-1:0]        hh_r   [NUM_AXES];
  logic [2*H-1:0]        hl_r   [NUM_AXES];
  logic [2*H-1:0]        ll_r   [NUM_AXES];
  logic [SQW-1:0]        sq_r   [NUM_AXES];
  logic [CCW-1:0]        cc_r;
  logic signed [DDW-1:0] dsq_r  [NUM_AXES];
  logic [DDW-1:0]        dd_r;

  assign pt[0]  = pt_x;
  assign pt[1]  = pt_y;
  assign pt[2]  = pt_z;
  assign org[0] = org_x;
  assign org[1] = org_y;
  assign org[2] = org_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  assign c_nxt[0] = CWD'(prod_r[0]) - CWD'(prod_r[1]);
  assign c_nxt[1] = CWD'(prod_r[2]) - CWD'(prod_r[3]);
  assign c_nxt[2] = CWD'(prod_r[4]) - CWD'(prod_r[5]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        a_r[k] <= AW'(pt[k]) - AW'(org[k]);
      end
      prod_r[0] <= PW'(a_r[1]) * PW'(dir[2]);
      prod_r[1] <= PW'(a_r[2]) * PW'(dir[1]);
      prod_r[2] <= PW'(a_r[2]) * PW'(dir[0]);
      prod_r[3] <= PW'(a_r[0]) * PW'(dir[2]);
      prod_r[4] <= PW'(a_r[0]) * PW'(dir[1]);
      prod_r[5] <= PW'(a_r[1]) * PW'(dir[0]);
      for (int k = 0; k < NUM_AXES; k++) begin
        cabs_r[k] <= c_nxt[k][CWD-1] ? CWD'(-c_nxt[k]) : CWD'(c_nxt[k]);
        hh_r[k]   <= (2*H)'(cabs_r[k][CWD-1:H]) * (2*H)'(cabs_r[k][CWD-1:H]);
        hl_r[k]   <= (2*H)'(cabs_r[k][CWD-1:H]) * (2*H)'(cabs_r[k][H-1:0]);
        ll_r[k]   <= (2*H)'(cabs_r[k][H-1:0]) * (2*H)'(cabs_r[k][H-1:0]);
        sq_r[k]   <= {hh_r[k], ll_r[k]} + (SQW'(hl_r[k]) << (H + 1));
      end
      cc_r <= CCW'(sq_r[0]) + CCW'(sq_r[1]) + CCW'(sq_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      dsq_r[k] <= DDW'(dir[k]) * DDW'(dir[k]);
    end
    dd_r <= DDW'(dsq_r[0]) + DDW'(dsq_r[1]) + DDW'(dsq_r[2]);
  end

  assign cc_valid = v_r[5];
  assign cc       = cc_r;
  assign dd       = dd_r;

endmodule

// ----- rtl/core/ptl_div.sv -----
// ----------------------------------------------------------------------------
// ptl_div: pipelined quotient of the squared lengths
// One restoring division step per stage gives floor(|c|^2 / |d|^2), with
// flags for a zero direction and for a quotient too large for the output.
// ----------------------------------------------------------------------------
module ptl_div #(
  parameter int CW = ptl_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             cc_valid,
  input  logic [4*CW+5:0]                  cc,
  input  logic [2*CW-1:0]                  dd,
  output ptl_pkg::ptl_ctl_t                q_ctl,
  output logic [ptl_pkg::QUOT_WIDTH-1:0]   quot
);
  import ptl_pkg::*;

  localparam int CCW = 4 * CW + 6;
  localparam int DDW = 2 * CW;
  localparam int QW  = QUOT_WIDTH;

  ptl_ctl_t       ctl_r [QW+1];
  logic [DDW-1:0] rem_r [QW+1];
  logic [QW-1:0]  lo_r  [QW+1];
  logic [QW-1:0]  q_r   [QW+1];
  logic [DDW-1:0] dd_r  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else if (adv) begin
      ctl_r[0].valid <= cc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0].degen <= (dd == '0);
      ctl_r[0].sat   <= (cc >> QW) >= CCW'(dd);
      rem_r[0]       <= DDW'(cc >> QW);
      lo_r[0]        <= cc[QW-1:0];
      q_r[0]         <= '0;
      dd_r[0]        <= dd;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DDW:0] t;
    logic         take;

    always_comb begin
      t    = {rem_r[j], lo_r[j][QW-1]};
      take = t >= {1'b0, dd_r[j]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1].valid <= 1'b0;
      end else if (adv) begin
        ctl_r[j+1].valid <= ctl_r[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[j+1].degen <= ctl_r[j].degen;
        ctl_r[j+1].sat   <= ctl_r[j].sat;
        rem_r[j+1]       <= take ? DDW'(t - {1'b0, dd_r[j]}) : DDW'(t);
        lo_r[j+1]        <= {lo_r[j][QW-2:0], 1'b0};
        q_r[j+1]         <= {q_r[j][QW-2:0], take};
        dd_r[j+1]        <= dd_r[j];
      end
    end
  end

  assign q_ctl = ctl_r[QW];
  assign quot  = q_r[QW];

endmodule

// ----- rtl/core/ptl_sqrt.sv -----
// ----------------------------------------------------------------------------
// ptl_sqrt: pipelined integer square root
// One root bit per stage, taking two bits of the quotient at a time.
// ----------------------------------------------------------------------------
module ptl_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  ptl_pkg::ptl_ctl_t              q_ctl,
  input  logic [ptl_pkg::QUOT_WIDTH-1:0] quot,
  output ptl_pkg::ptl_ctl_t              r_ctl,
  output logic [ptl_pkg::OUT_WIDTH-1:0]  root
);
  import ptl_pkg::*;

  localparam int OW = OUT_WIDTH;
  localparam int QW = QUOT_WIDTH;
  localparam int RW = OW + 2;

  ptl_ctl_t      ctl_r  [OW+1];
  logic [RW-1:0] rem_r  [OW+1];
  logic [OW-1:0] root_r [OW+1];
  logic [QW-1:0] xs_r   [OW+1];

  assign ctl_r[0]  = q_ctl;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign xs_r[0]   = quot;

  for (genvar j = 0; j < OW; j++) begin : g_step
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          take;

    always_comb begin
      cur   = {rem_r[j], xs_r[j][QW-1:QW-2]};
      trial = (RW+2)'({root_r[j], 2'b01});
      take  = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1].valid <= 1'b0;
      end else if (adv) begin
        ctl_r[j+1].valid <= ctl_r[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[j+1].degen <= ctl_r[j].degen;
        ctl_r[j+1].sat   <= ctl_r[j].sat;
        rem_r[j+1]       <= take ? RW'(cur - trial) : RW'(cur);
        root_r[j+1]      <= {root_r[j][OW-2:0], take};
        xs_r[j+1]        <= {xs_r[j][QW-3:0], 2'b00};
      end
    end
  end

  assign r_ctl = ctl_r[OW];
  assign root  = root_r[OW];

endmodule
